// ===== rtl/core/rpfa_pkg.sv =====
// Shared constants, command and status codes, and control types for the
// reference-counted page-frame allocator. No dependencies.
`default_nettype none

package rpfa_pkg;

   localparam int NUM_PAGES = 512;
   localparam int WORD_BITS = 32;
   localparam int REF_BITS  = 8;
   localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;

   localparam int PAGE_W = $clog2(NUM_PAGES);
   localparam int BIT_W  = $clog2(WORD_BITS);
   localparam int WIDX_W = $clog2(NUM_WORDS);
   localparam int CNT_W  = $clog2(NUM_PAGES + 1);
   localparam int FUP_W  = 10;
   localparam int CMD_W  = 2;
   localparam int STS_W  = 2;

   localparam int REQ_DATA_W = ((PAGE_W + 7) / 8) * 8;
   localparam int RSP_BITS   = PAGE_W + REF_BITS + CNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [REF_BITS-1:0] REF_MAX = '1;
   localparam logic [FUP_W-1:0]    FUP_RESET = FUP_W'(1);

   localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_REL   = 2'd3;

   localparam logic [STS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STS_W-1:0] ST_NOFREE = 2'd1;
   localparam logic [STS_W-1:0] ST_UNREF  = 2'd2;
   localparam logic [STS_W-1:0] ST_SAT    = 2'd3;

   typedef struct packed {
      logic capture;
      logic clr_step;
      logic clr_init;
      logic scan_step;
      logic scan_fail;
      logic upd;
      logic load_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic scan_hit;
      logic scan_last;
      logic total_zero;
   } dp_sts_type;

   typedef struct packed {
      logic [CNT_W-1:0]    free_pages;
      logic [REF_BITS-1:0] ref_count;
      logic [PAGE_W-1:0]   page_out;
      logic [STS_W-1:0]    status;
   } res_type;

endpackage

`default_nettype wire

// ===== rtl/core/rpfa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module rpfa_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/rpfa_ctrl.sv =====
// Controller state machine of the page-frame allocator: sequences clearing,
// scanning and count updates, and owns both handshakes. Uses rpfa_pkg.
`default_nettype none

module rpfa_ctrl
   import rpfa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [CMD_W-1:0] req_cmd,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire dp_sts_type       sts,
   output ctl_cmd_type           cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_INIT  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_MOD   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_cmd)
                  CMD_INIT:  state_in = S_INIT;
                  CMD_ALLOC: state_in = S_SCAN;
                  default:   state_in = S_READ;
               endcase
            end
         end
         S_INIT: begin
            cmd.clr_step = 1'b1;
            cmd.clr_init = 1'b1;
            if (sts.clr_last) begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (sts.total_zero) begin
               cmd.scan_fail = 1'b1;
               state_in      = S_DONE;
            end else if (sts.scan_hit) begin
               cmd.scan_step = 1'b1;
               state_in      = S_DONE;
            end else if (sts.scan_last) begin
               cmd.scan_fail = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_READ: begin
            state_in = S_MOD;
         end
         S_MOD: begin
            cmd.upd  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // A nonzero free count guarantees a free bit somewhere in one full lap.
   a_scan_finds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && !sts.total_zero && sts.scan_last) |-> sts.scan_hit)
      else $error("scan lap ended without a free page despite nonzero count");

   // A new word is never loaded over one that the receiver has not taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && rsp_valid_ff) |-> rsp_ready)
      else $error("result word overwritten before it was taken");

   // A word waiting for the receiver stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("result word dropped before it was taken");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rpfa_dp.sv =====
// Datapath of the page-frame allocator: free bitmap, reference-count RAM,
// scan pointer, free count, configuration register and result registers.
// Uses rpfa_pkg and rpfa_ram.
`default_nettype none

module rpfa_dp
   import rpfa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_cmd_type       cmd,
   output dp_sts_type             sts,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [PAGE_W-1:0] req_page,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [FUP_W-1:0]  csr_data,
   output res_type                out
);

   logic [WORD_BITS-1:0] bitmap_ff [NUM_WORDS];
   logic [WIDX_W-1:0]    bm_addr_in;
   logic [WORD_BITS-1:0] bm_word_in;
   logic                 bm_we;

   logic [FUP_W-1:0]  fup_ff, fup_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [PAGE_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [WIDX_W-1:0] scan_w_ff, scan_w_in;
   logic [WIDX_W-1:0] scan_k_ff, scan_k_in;
   logic [WIDX_W-1:0] search_ff, search_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   res_type           res_ff, res_in;
   res_type           out_ff;

   logic                   ram_we;
   logic [PAGE_W-1:0]      ram_waddr;
   logic [REF_BITS-1:0]    ram_wdata;
   logic [REF_BITS-1:0]    ref_rd;

   logic [WIDX_W-1:0]      clr_w;
   logic [FUP_W-BIT_W-1:0] fup_w;
   logic [WORD_BITS-1:0]   init_word;
   logic [CNT_W-1:0]       init_total;
   logic                   init_last;

   logic [WORD_BITS-1:0] scan_bits;
   logic [BIT_W-1:0]     scan_b;
   logic                 hit;
   logic [PAGE_W-1:0]    hit_page;

   logic [WIDX_W-1:0]    pg_w;
   logic [BIT_W-1:0]     pg_b;
   logic [WORD_BITS-1:0] pg_word;
   logic                 pg_free;
   logic [REF_BITS-1:0]  new_ref;
   logic                 upd_we;
   logic                 free_it;
   logic [STS_W-1:0]     upd_status;

   assign csr_ready = 1'b1;
   assign out       = out_ff;

   rpfa_ram #(
      .WIDTH (REF_BITS),
      .DEPTH (NUM_PAGES)
   ) u_refs (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (page_ff),
      .rd_data (ref_rd)
   );

   // Init pattern of one bitmap word: pages at or above first_user_page are free.
   assign clr_w  = clr_cnt_ff[PAGE_W-1:BIT_W];
   assign fup_w  = fup_ff[FUP_W-1:BIT_W];
   always_comb begin
      if ({1'b0, clr_w} > fup_w) begin
         init_word = '1;
      end else if ({1'b0, clr_w} == fup_w) begin
         init_word = {WORD_BITS{1'b1}} << fup_ff[BIT_W-1:0];
      end else begin
         init_word = '0;
      end
   end
   assign init_total = (fup_ff >= FUP_W'(NUM_PAGES)) ? '0
                                                    : CNT_W'(NUM_PAGES) - CNT_W'(fup_ff);
   assign init_last  = cmd.clr_step && cmd.clr_init && sts.clr_last;

   assign scan_bits = bitmap_ff[scan_w_ff];
   assign hit       = (scan_bits != '0);
   always_comb begin
      scan_b = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (scan_bits[i]) begin
            scan_b = BIT_W'(i);
         end
      end
   end
   assign hit_page = {scan_w_ff, scan_b};

   assign pg_w    = page_ff[PAGE_W-1:BIT_W];
   assign pg_b    = page_ff[BIT_W-1:0];
   assign pg_word = bitmap_ff[pg_w];
   assign pg_free = pg_word[pg_b];

   always_comb begin
      new_ref    = ref_rd;
      upd_we     = 1'b0;
      free_it    = 1'b0;
      upd_status = ST_OK;
      if (cmd_ff == CMD_ADD) begin
         if (ref_rd == REF_MAX) begin
            upd_status = ST_SAT;
         end else begin
            new_ref = ref_rd + REF_BITS'(1);
            upd_we  = 1'b1;
         end
      end else begin
         if (ref_rd == '0) begin
            upd_status = ST_UNREF;
         end else begin
            new_ref = ref_rd - REF_BITS'(1);
            upd_we  = 1'b1;
            free_it = (new_ref == '0) && !pg_free;
         end
      end
   end

   always_comb begin
      sts.clr_last   = (clr_cnt_ff == PAGE_W'(NUM_PAGES - 1));
      sts.scan_hit   = hit;
      sts.scan_last  = (scan_k_ff == WIDX_W'(NUM_WORDS - 1));
      sts.total_zero = (total_ff == '0);
   end

   always_comb begin
      fup_in     = csr_valid ? csr_data : fup_ff;
      clr_cnt_in = cmd.clr_step ? clr_cnt_ff + PAGE_W'(1) : clr_cnt_ff;
      scan_w_in  = scan_w_ff;
      scan_k_in  = scan_k_ff;
      search_in  = search_ff;
      total_in   = total_ff;
      res_in     = res_ff;
      bm_we      = 1'b0;
      bm_addr_in = pg_w;
      bm_word_in = pg_word;
      ram_we     = 1'b0;
      ram_waddr  = page_ff;
      ram_wdata  = new_ref;

      if (cmd.capture) begin
         scan_w_in = search_ff;
         scan_k_in = '0;
      end

      if (cmd.clr_step) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
         if (cmd.clr_init) begin
            bm_we      = 1'b1;
            bm_addr_in = clr_w;
            bm_word_in = init_word;
         end
         if (init_last) begin
            search_in = '0;
            total_in  = init_total;
            res_in    = '{free_pages: init_total, ref_count: '0, page_out: '0,
                          status: ST_OK};
         end
      end

      if (cmd.scan_step) begin
         if (hit) begin
            bm_we      = 1'b1;
            bm_addr_in = scan_w_ff;
            bm_word_in = scan_bits & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << scan_b);
            ram_we     = 1'b1;
            ram_waddr  = hit_page;
            ram_wdata  = REF_BITS'(1);
            search_in  = scan_w_ff;
            total_in   = total_ff - CNT_W'(1);
            res_in     = '{free_pages: total_ff - CNT_W'(1), ref_count: REF_BITS'(1),
                           page_out: hit_page, status: ST_OK};
         end else begin
            scan_w_in = (scan_w_ff == WIDX_W'(NUM_WORDS - 1)) ? '0
                                                              : scan_w_ff + WIDX_W'(1);
            scan_k_in = scan_k_ff + WIDX_W'(1);
         end
      end

      if (cmd.scan_fail) begin
         res_in = '{free_pages: total_ff, ref_count: '0, page_out: '0, status: ST_NOFREE};
      end

      if (cmd.upd) begin
         ram_we = upd_we;
         if (free_it) begin
            bm_we      = 1'b1;
            bm_word_in = pg_word | ({{(WORD_BITS-1){1'b0}}, 1'b1} << pg_b);
            total_in   = total_ff + CNT_W'(1);
         end
         res_in = '{free_pages: free_it ? total_ff + CNT_W'(1) : total_ff,
                    ref_count: new_ref, page_out: page_ff, status: upd_status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fup_ff     <= FUP_RESET;
         clr_cnt_ff <= '0;
         search_ff  <= '0;
         total_ff   <= '0;
         for (int i = 0; i < NUM_WORDS; i++) begin
            bitmap_ff[i] <= '0;
         end
      end else begin
         fup_ff     <= fup_in;
         clr_cnt_ff <= clr_cnt_in;
         search_ff  <= search_in;
         total_ff   <= total_in;
         if (bm_we) begin
            bitmap_ff[bm_addr_in] <= bm_word_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_cmd;
         page_ff <= req_page;
      end
      scan_w_ff <= scan_w_in;
      scan_k_ff <= scan_k_in;
      res_ff    <= res_in;
      if (cmd.load_out) begin
         out_ff <= res_ff;
      end
   end

`ifndef SYNTHESIS
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(NUM_PAGES))
      else $error("free count exceeds the number of pages");

   a_hit_needs_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && hit) |-> (total_ff != '0))
      else $error("allocation hit while the free count is zero");

   a_free_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.upd && free_it) |=> (total_ff == $past(total_ff) + CNT_W'(1)))
      else $error("freed page not added to the free count");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/refcounted_page_frame_allocator_top.sv =====
// Top level of the reference-counted page-frame allocator.
// Joins rpfa_ctrl and rpfa_dp; uses rpfa_pkg.
//
// Usage: one command word enters on req_ (tuser carries the command, tdata the
// page), one result word leaves on rsp_ for every command. csr_ writes the
// first user page and is always ready; write it only while the block is idle.
// From acceptance to the result word, add reference and release read the count
// RAM, update the count and output it; allocate examines one bitmap word per
// cycle starting at the next-fit word; init clears one count RAM entry per cycle.
// A new command is accepted on the cycle after the result is registered, so
// commands do not overlap: each one finishes before the next is accepted.
// After reset a clearing pass zeroes every reference count; no command is
// accepted during it. Reset leaves every page used and the free count at zero
// until an init command.
// A stalled receiver holds the result word in the output register; the next
// command is still accepted and finishes, then waits until that word is taken.
`default_nettype none

module refcounted_page_frame_allocator_top
   import rpfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // page
   input  wire logic [CMD_W-1:0]      req_tuser,   // cmd
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // page_out, ref_count, free_pages
   output logic [STS_W-1:0]           rsp_tuser,   // status
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [FUP_W-1:0]      csr_data
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;
   res_type     out;

   rpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rpfa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_cmd   (req_tuser),
      .req_page  (req_tdata[PAGE_W-1:0]),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .out       (out)
   );

   assign rsp_tdata = RSP_DATA_W'({out.free_pages, out.ref_count, out.page_out});
   assign rsp_tuser = out.status;

endmodule

`default_nettype wire
